[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with active-low reset as disable.
`define TTCC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Expression that must never hold at a clock edge.
`define TTCC_ASSERT_NEVER(lbl, clk, rstn, expr, msg) \
    `TTCC_ASSERT(lbl, clk, rstn, !(expr), msg)

`endif

[hw/rtl/ttcc_pkg.sv]
// Shared types and constants for the thermal throttle cap combiner.
// No dependencies.
`default_nettype none

package ttcc_pkg;

    localparam int KHZ_W     = 24;
    localparam int LVL_W     = 5;
    localparam int CNT_W     = 16;
    localparam int TOT_W     = 18;
    localparam int LEN_W     = 6;
    localparam int SLOT_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int MASK_W    = 3;

    localparam logic [KHZ_W-1:0] NO_CAP        = 24'hFFFFFF;
    localparam logic [KHZ_W-1:0] LOWEST_MARK   = 24'h000000;
    localparam logic [KHZ_W-1:0] BUS_MAX_RESET = 24'hFFFFFE;

    localparam logic [1:0] OP_LEVEL  = 2'd0;
    localparam logic [1:0] OP_CAP_WR = 2'd1;
    localparam logic [1:0] OP_CPU_WR = 2'd2;
    localparam logic [1:0] OP_GOV    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_CPU_LOWEST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS0_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS1_MAX   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUS2_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_EXACT      = 3'd5;

    typedef struct packed {
        logic             start;
        logic [KHZ_W-1:0] cap;
        logic [LEN_W-1:0] len;
    } t_clip_req;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [KHZ_W-1:0]  data;
    } t_tbl_wr;

    typedef struct packed {
        logic             done;
        logic [KHZ_W-1:0] value;
    } t_clip_rsp;

endpackage

`default_nettype wire

[hw/rtl/ttcc_clip.sv]
// CPU frequency table store and the walk that clips a cap to a table entry.
// Depends on ttcc_pkg.
`default_nettype none

module ttcc_clip #(
    parameter int DEPTH = 32
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  ttcc_pkg::t_tbl_wr    i_wr,
    input  ttcc_pkg::t_clip_req  i_req,
    output ttcc_pkg::t_clip_rsp  o_rsp
);
    import ttcc_pkg::*;

    localparam int TW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);

    localparam logic [1:0] C_IDLE = 2'd0;
    localparam logic [1:0] C_RD   = 2'd1;
    localparam logic [1:0] C_CMP  = 2'd2;

    logic [KHZ_W-1:0] r_mem [DEPTH];
    logic [KHZ_W-1:0] r_rd;

    logic [1:0]       r_state, n_state;
    logic [TW-1:0]    r_idx, n_idx;
    logic [KHZ_W-1:0] r_cap, n_cap;
    logic [KHZ_W-1:0] r_prev, n_prev;
    logic             r_done, n_done;
    logic [KHZ_W-1:0] r_val, n_val;

    logic [LW-1:0]    len_eff;

    always_comb begin
        if (32'(i_req.len) > DEPTH) begin
            len_eff = LW'(DEPTH);
        end else begin
            len_eff = LW'(i_req.len);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en && (32'(i_wr.slot) < DEPTH)) begin
            r_mem[TW'(i_wr.slot)] <= i_wr.data;
        end
        r_rd <= r_mem[r_idx];
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_cap   = r_cap;
        n_prev  = r_prev;
        n_val   = r_val;
        n_done  = 1'b0;
        unique case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_cap = i_req.cap;
                    n_idx = '0;
                    if (len_eff == '0) begin
                        n_val  = i_req.cap;
                        n_done = 1'b1;
                    end else begin
                        n_state = C_RD;
                    end
                end
            end
            C_RD: begin
                n_state = C_CMP;
            end
            C_CMP: begin
                if (r_rd > r_cap) begin
                    n_val   = (r_idx == '0) ? r_rd : r_prev;
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end else if ((LW'(r_idx) + LW'(1)) == len_eff) begin
                    n_val   = r_rd;
                    n_done  = 1'b1;
                    n_state = C_IDLE;
                end else begin
                    n_prev  = r_rd;
                    n_idx   = r_idx + TW'(1);
                    n_state = C_RD;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_idx   <= n_idx;
        end
        r_cap  <= n_cap;
        r_prev <= n_prev;
        r_val  <= n_val;
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_val;

endmodule

`default_nettype wire

[hw/rtl/thermal_throttle_cap_combiner.sv]
// Top level: source levels, cap table memory, min sweep, bus rate update, CPU cap.
// Depends on ttcc_pkg and ttcc_clip.
//
//  channel   handshake                 payload
//  --------  ------------------------  ---------------------------------------------
//  command   start / busy              i_op i_source i_level i_row i_column i_slot i_value
//  result    o_done strobe, 1 cycle    o_cpu_cap_khz o_bus*_rate_khz o_change_mask ...
//  config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// Table writes, governor requests and level ops that change nothing: result in the
// cycle after the transfer, next command accepted that cycle.
// Level change: cap table reads for every source and column through the one min
// comparator, a drain step, one rate update per bus clock, a CPU cap step, plus
// a table walk when clipping; busy meanwhile.
// Synchronous reset; no clearing pass. Config is always ready; results cannot stall.
`default_nettype none

module thermal_throttle_cap_combiner #(
    parameter int SOURCES         = 4,
    parameter int ROWS            = 16,
    parameter int BUS_CLOCKS      = 3,
    parameter int CPU_TABLE_DEPTH = 32
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_op,
    input  wire  [1:0]                          i_source,
    input  wire  [ttcc_pkg::LVL_W-1:0]          i_level,
    input  wire  [3:0]                          i_row,
    input  wire  [1:0]                          i_column,
    input  wire  [ttcc_pkg::SLOT_W-1:0]         i_slot,
    input  wire  [ttcc_pkg::KHZ_W-1:0]          i_value,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [ttcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire  [ttcc_pkg::KHZ_W-1:0]          i_cfg_data,
    output logic                                o_done,
    output logic [ttcc_pkg::KHZ_W-1:0]          o_cpu_cap_khz,
    output logic [ttcc_pkg::KHZ_W-1:0]          o_bus0_rate_khz,
    output logic [ttcc_pkg::KHZ_W-1:0]          o_bus1_rate_khz,
    output logic [ttcc_pkg::KHZ_W-1:0]          o_bus2_rate_khz,
    output logic [ttcc_pkg::MASK_W-1:0]         o_change_mask,
    output logic                                o_raise_order,
    output logic                                o_throttling,
    output logic [ttcc_pkg::TOT_W-1:0]          o_total_count,
    output logic [ttcc_pkg::KHZ_W-1:0]          o_granted_speed
);
    import ttcc_pkg::*;

    localparam int COLS      = BUS_CLOCKS + 1;
    localparam int SW        = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int RW        = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CLW       = $clog2(COLS);
    localparam int BW        = (BUS_CLOCKS > 1) ? $clog2(BUS_CLOCKS) : 1;
    localparam int AW        = SW + RW + CLW;
    localparam int CAP_DEPTH = 2 ** AW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_DRAIN = 3'd2;
    localparam logic [2:0] S_BUS   = 3'd3;
    localparam logic [2:0] S_CPU   = 3'd4;
    localparam logic [2:0] S_CLIP  = 3'd5;

    // configuration
    logic [KHZ_W-1:0] r_cpu_lowest;
    logic [KHZ_W-1:0] r_bus_max [3];
    logic [LEN_W-1:0] r_cpu_len;
    logic             r_exact;

    // cap table
    logic [KHZ_W-1:0] r_cap_mem [CAP_DEPTH];
    logic [KHZ_W-1:0] r_rd;
    logic             cap_wr_en;
    logic [AW-1:0]    cap_wr_addr;
    logic [AW-1:0]    cap_rd_addr;

    // control and state
    logic [2:0]        r_state, n_state;
    logic [LVL_W-1:0]  r_level [SOURCES];
    logic [LVL_W-1:0]  n_level [SOURCES];
    logic [CNT_W-1:0]  r_entry [SOURCES];
    logic [CNT_W-1:0]  n_entry [SOURCES];
    logic [TOT_W-1:0]  r_total, n_total;
    logic [KHZ_W-1:0]  r_cpu_cap, n_cpu_cap;
    logic [KHZ_W-1:0]  r_applied [BUS_CLOCKS];
    logic [KHZ_W-1:0]  n_applied [BUS_CLOCKS];
    logic [KHZ_W-1:0]  r_mins [COLS];
    logic [KHZ_W-1:0]  n_mins [COLS];
    logic [SW-1:0]     r_k, n_k;
    logic [CLW-1:0]    r_c, n_c;
    logic [BW-1:0]     r_b, n_b;
    logic              r_pend_v, n_pend_v;
    logic [CLW-1:0]    r_pend_col, n_pend_col;
    logic              r_done, n_done;
    logic [MASK_W-1:0] r_change, n_change;
    logic              r_order, n_order;
    logic [KHZ_W-1:0]  r_granted, n_granted;

    // derived
    logic             src_ok;
    logic [SW-1:0]    src_idx;
    logic [LVL_W-1:0] lvl_clamp;
    logic [LVL_W-1:0] lvl_k;
    logic [CLW-1:0]   bus_col;
    logic [CLW-1:0]   min_idx;
    logic [KHZ_W-1:0] min_rd;
    logic [KHZ_W-1:0] bus_max_sel;
    logic [KHZ_W-1:0] bus_rate;
    logic             thr;

    t_clip_req clip_req;
    t_clip_rsp clip_rsp;
    t_tbl_wr   tbl_wr;

    assign src_ok    = (32'(i_source) < SOURCES);
    assign src_idx   = SW'(i_source);
    assign lvl_clamp = (32'(i_level) > ROWS) ? LVL_W'(ROWS) : i_level;
    assign lvl_k     = r_level[r_k];
    assign bus_col   = CLW'(32'(r_b) + 1);
    assign min_idx   = (r_state == S_BUS) ? bus_col : r_pend_col;
    assign min_rd    = r_mins[min_idx];

    assign cap_wr_addr = {src_idx, RW'(i_row), CLW'(i_column)};
    assign cap_rd_addr = {r_k, RW'(lvl_k - LVL_W'(1)), r_c};

    always_comb begin
        unique case (2'(r_b))
            2'd0:    bus_max_sel = r_bus_max[0];
            2'd1:    bus_max_sel = r_bus_max[1];
            2'd2:    bus_max_sel = r_bus_max[2];
            default: bus_max_sel = BUS_MAX_RESET;
        endcase
    end

    assign bus_rate = (min_rd == NO_CAP) ? bus_max_sel : min_rd;

    always_comb begin
        thr = 1'b0;
        for (int k = 0; k < SOURCES; k++) begin
            thr = thr | (r_level[k] != '0);
        end
    end

    // cap table memory
    always_ff @(posedge i_clk) begin
        if (cap_wr_en) begin
            r_cap_mem[cap_wr_addr] <= i_value;
        end
        r_rd <= r_cap_mem[cap_rd_addr];
    end

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpu_lowest <= '0;
            r_bus_max[0] <= BUS_MAX_RESET;
            r_bus_max[1] <= BUS_MAX_RESET;
            r_bus_max[2] <= BUS_MAX_RESET;
            r_cpu_len    <= '0;
            r_exact      <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CPU_LOWEST: r_cpu_lowest <= i_cfg_data;
                CFG_BUS0_MAX:   r_bus_max[0] <= i_cfg_data;
                CFG_BUS1_MAX:   r_bus_max[1] <= i_cfg_data;
                CFG_BUS2_MAX:   r_bus_max[2] <= i_cfg_data;
                CFG_TABLE_LEN:  r_cpu_len    <= i_cfg_data[LEN_W-1:0];
                CFG_EXACT:      r_exact      <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        n_state    = r_state;
        n_level    = r_level;
        n_entry    = r_entry;
        n_total    = r_total;
        n_cpu_cap  = r_cpu_cap;
        n_applied  = r_applied;
        n_mins     = r_mins;
        n_k        = r_k;
        n_c        = r_c;
        n_b        = r_b;
        n_pend_v   = 1'b0;
        n_pend_col = r_pend_col;
        n_done     = 1'b0;
        n_change   = r_change;
        n_order    = r_order;
        n_granted  = r_granted;
        cap_wr_en  = 1'b0;
        clip_req   = '0;
        clip_req.len = r_cpu_len;
        tbl_wr      = '0;
        tbl_wr.slot = i_slot;
        tbl_wr.data = i_value;

        // min compare for the read issued last cycle
        if (r_pend_v && (r_rd < min_rd)) begin
            n_mins[r_pend_col] = r_rd;
        end

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_change  = '0;
                    n_order   = 1'b0;
                    n_granted = '0;
                    unique case (i_op)
                        OP_LEVEL: begin
                            if (src_ok && (r_cpu_len != '0) &&
                                (lvl_clamp != r_level[src_idx])) begin
                                if (r_level[src_idx] == '0) begin
                                    n_entry[src_idx] = r_entry[src_idx] + CNT_W'(1);
                                    if (r_entry[src_idx] == {CNT_W{1'b1}}) begin
                                        n_total = r_total - TOT_W'({CNT_W{1'b1}});
                                    end else begin
                                        n_total = r_total + TOT_W'(1);
                                    end
                                end
                                n_order          = (r_level[src_idx] > lvl_clamp);
                                n_level[src_idx] = lvl_clamp;
                                for (int c = 0; c < COLS; c++) begin
                                    n_mins[c] = NO_CAP;
                                end
                                n_k     = '0;
                                n_c     = '0;
                                n_state = S_SWEEP;
                            end else begin
                                n_done = 1'b1;
                            end
                        end
                        OP_CAP_WR: begin
                            cap_wr_en = src_ok && (32'(i_row) < ROWS) &&
                                        (32'(i_column) < COLS);
                            n_done    = 1'b1;
                        end
                        OP_CPU_WR: begin
                            tbl_wr.en = 1'b1;
                            n_done    = 1'b1;
                        end
                        OP_GOV: begin
                            if ((r_cpu_cap == NO_CAP) || (r_cpu_cap == '0)) begin
                                n_granted = i_value;
                            end else begin
                                n_granted = (i_value < r_cpu_cap) ? i_value : r_cpu_cap;
                            end
                            n_done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                n_pend_v   = (lvl_k != '0);
                n_pend_col = r_c;
                if (r_c == CLW'(COLS - 1)) begin
                    n_c = '0;
                    if (r_k == SW'(SOURCES - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_k = r_k + SW'(1);
                    end
                end else begin
                    n_c = r_c + CLW'(1);
                end
            end
            S_DRAIN: begin
                n_b     = '0;
                n_state = S_BUS;
            end
            S_BUS: begin
                if (r_applied[r_b] != bus_rate) begin
                    n_applied[r_b] = bus_rate;
                    if (32'(r_b) < MASK_W) begin
                        n_change[2'(r_b)] = 1'b1;
                    end
                end
                if (r_b == BW'(BUS_CLOCKS - 1)) begin
                    n_state = S_CPU;
                end else begin
                    n_b = r_b + BW'(1);
                end
            end
            S_CPU: begin
                if (r_mins[0] == LOWEST_MARK) begin
                    n_cpu_cap = r_cpu_lowest;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else if (r_exact) begin
                    n_cpu_cap = r_mins[0];
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    clip_req.start = 1'b1;
                    clip_req.cap   = r_mins[0];
                    n_state        = S_CLIP;
                end
            end
            S_CLIP: begin
                if (clip_rsp.done) begin
                    n_cpu_cap = clip_rsp.value;
                    n_done    = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_total   <= '0;
            r_cpu_cap <= NO_CAP;
            r_pend_v  <= 1'b0;
            r_done    <= 1'b0;
            r_change  <= '0;
            r_order   <= 1'b0;
            r_granted <= '0;
            r_k       <= '0;
            r_c       <= '0;
            r_b       <= '0;
            for (int k = 0; k < SOURCES; k++) begin
                r_level[k] <= '0;
                r_entry[k] <= '0;
            end
            for (int c = 0; c < BUS_CLOCKS; c++) begin
                r_applied[c] <= BUS_MAX_RESET;
            end
        end else begin
            r_state   <= n_state;
            r_total   <= n_total;
            r_cpu_cap <= n_cpu_cap;
            r_pend_v  <= n_pend_v;
            r_done    <= n_done;
            r_change  <= n_change;
            r_order   <= n_order;
            r_granted <= n_granted;
            r_k       <= n_k;
            r_c       <= n_c;
            r_b       <= n_b;
            r_level   <= n_level;
            r_entry   <= n_entry;
            r_applied <= n_applied;
        end
        r_mins     <= n_mins;
        r_pend_col <= n_pend_col;
    end

    ttcc_clip #(
        .DEPTH (CPU_TABLE_DEPTH)
    ) u_clip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (tbl_wr),
        .i_req   (clip_req),
        .o_rsp   (clip_rsp)
    );

    assign busy            = (r_state != S_IDLE);
    assign o_done          = r_done;
    assign o_cpu_cap_khz   = r_cpu_cap;
    assign o_change_mask   = r_change;
    assign o_raise_order   = r_order;
    assign o_throttling    = thr;
    assign o_total_count   = r_total;
    assign o_granted_speed = r_granted;
    assign o_bus0_rate_khz = r_applied[0];

    generate
        if (BUS_CLOCKS > 1) begin : g_bus1
            assign o_bus1_rate_khz = r_applied[1];
        end else begin : g_bus1_fixed
            assign o_bus1_rate_khz = BUS_MAX_RESET;
        end
        if (BUS_CLOCKS > 2) begin : g_bus2
            assign o_bus2_rate_khz = r_applied[2];
        end else begin : g_bus2_fixed
            assign o_bus2_rate_khz = BUS_MAX_RESET;
        end
    endgenerate

endmodule

`default_nettype wire

[hw/rtl/ttcc_checker.sv]
// Port-level checks on the combiner's command and result timing, bound to the top.
// Depends on ttcc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module ttcc_checker (
    input wire                          i_clk,
    input wire                          i_rst_n,
    input wire                          start,
    input wire                          busy,
    input wire [1:0]                    i_op,
    input wire                          o_done,
    input wire [ttcc_pkg::MASK_W-1:0]   o_change_mask,
    input wire                          o_raise_order
);
    import ttcc_pkg::*;

    `TTCC_ASSERT(a_short_op_done, i_clk, i_rst_n, (start && !busy && i_op != OP_LEVEL) |=> o_done, "non-level op must finish in one cycle")
    `TTCC_ASSERT_NEVER(a_done_while_busy, i_clk, i_rst_n, o_done && busy, "result strobe while busy")
    `TTCC_ASSERT(a_busy_end_done, i_clk, i_rst_n, ($fell(busy) && $past(i_rst_n)) |-> o_done, "busy dropped without a result")
    `TTCC_ASSERT(a_change_after_work, i_clk, i_rst_n, (o_done && (o_change_mask != 3'b000 || o_raise_order)) |-> $past(busy), "rate change flagged without a level sweep")

endmodule

bind thermal_throttle_cap_combiner ttcc_checker u_ttcc_checker (.*);

`default_nettype wire
